// ----- rtl/core/lrd_pkg.sv -----
`default_nettype none
package lrd_pkg;

    // Table sizes
    localparam int NUM_LOCKS   = 32;
    localparam int NUM_THREADS = 16;
    localparam int NUM_VARS    = 1024;

    localparam int LOCK_IDX_W = $clog2(NUM_LOCKS);
    localparam int THR_IDX_W  = $clog2(NUM_THREADS);
    localparam int VAR_AW     = $clog2(NUM_VARS);

    // Event kinds
    typedef enum logic [1:0] {
        EV_LOCK   = 2'd0,
        EV_UNLOCK = 2'd1,
        EV_READ   = 2'd2,
        EV_WRITE  = 2'd3
    } t_ev_kind;

    // Variable states
    typedef enum logic [1:0] {
        VS_VIRGIN = 2'd0,
        VS_EXCL   = 2'd1,
        VS_SHARED = 2'd2,
        VS_SHMOD  = 2'd3
    } t_var_st;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_lrd_state;

    // Input transaction
    typedef struct packed {
        t_ev_kind    kind;
        logic [3:0]  thread_slot;
        logic [4:0]  lock_index;
        logic [9:0]  var_slot;
    } t_lrd_in;

    // Result transaction
    typedef struct packed {
        logic    race_now;
        logic    race_seen;
        t_var_st var_state;
    } t_lrd_out;

    // One entry of the variable table
    typedef struct packed {
        t_var_st                status;
        logic [NUM_LOCKS-1:0]   cand;
        logic [THR_IDX_W-1:0]   owner;
    } t_var_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } t_lrd_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_lrd_sts;

endpackage
`default_nettype wire

// ----- rtl/core/lrd_ram.sv -----
`default_nettype none
module lrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/core/lrd_ctrl.sv -----
`default_nettype none
module lrd_ctrl
    import lrd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_lrd_sts i_sts,
    output t_lrd_cmd      o_cmd,
    output logic          o_busy
);

    t_lrd_state r_state;
    t_lrd_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A transaction is always executed in the cycle right after it is taken
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("load not followed by exec");

    // Clearing never overlaps with event processing
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> !o_cmd.load && !o_cmd.exec)
        else $error("clear overlaps event work");

endmodule
`default_nettype wire

// ----- rtl/core/lrd_datapath.sv -----
`default_nettype none
module lrd_datapath
    import lrd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_lrd_cmd i_cmd,
    input  wire t_lrd_in  i_item,
    output t_lrd_sts      o_sts,
    output logic          o_valid,
    output t_lrd_out      o_result
);

    // Captured event
    t_lrd_in r_item;

    // Per-thread held lock sets
    logic [NUM_LOCKS-1:0] r_held [NUM_THREADS];

    // Clearing pass address
    logic [VAR_AW-1:0] r_clr_addr;

    // Result registers
    logic     r_valid;
    t_lrd_out r_out;
    logic     r_race_flag;

    // Variable table port signals
    t_var_entry        rd_entry;
    t_var_entry        wr_entry;
    logic              ram_we;
    logic [VAR_AW-1:0] ram_waddr;

    // Decoded event
    logic                  thr_ok;
    logic                  lock_ok;
    logic                  var_ok;
    logic                  is_access;
    logic                  acc_ok;
    logic [THR_IDX_W-1:0]  tidx;
    logic [LOCK_IDX_W-1:0] lidx;
    logic [VAR_AW-1:0]     vidx;
    logic [NUM_LOCKS-1:0]  held;
    logic                  other;
    t_var_st               st;
    logic [NUM_LOCKS-1:0]  cand;
    logic [THR_IDX_W-1:0]  owner;
    logic                  race;

    // Capture the event on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    assign thr_ok    = int'(r_item.thread_slot) < NUM_THREADS;
    assign lock_ok   = int'(r_item.lock_index) < NUM_LOCKS;
    assign var_ok    = int'(r_item.var_slot) < NUM_VARS;
    assign is_access = (r_item.kind == EV_READ) || (r_item.kind == EV_WRITE);
    assign acc_ok    = thr_ok && var_ok && is_access;
    assign tidx      = THR_IDX_W'(r_item.thread_slot);
    assign lidx      = LOCK_IDX_W'(r_item.lock_index);
    assign vidx      = VAR_AW'(r_item.var_slot);
    assign held      = r_held[tidx];

    // Lockset refinement
    always_comb begin
        st    = rd_entry.status;
        cand  = rd_entry.cand;
        owner = rd_entry.owner;
        race  = 1'b0;
        other = rd_entry.owner != tidx;
        if (r_item.kind == EV_READ) begin
            unique case (rd_entry.status)
                VS_VIRGIN: begin
                    owner = tidx;
                end
                VS_EXCL: begin
                    if (held != '0) begin
                        cand = held;
                    end
                    if (other) begin
                        st = VS_SHARED;
                    end
                end
                VS_SHARED, VS_SHMOD: begin
                    if (held != '0) begin
                        cand = cand & held;
                    end
                    race = (rd_entry.status == VS_SHMOD) && (cand == '0);
                end
                default: ;
            endcase
        end else begin
            unique case (rd_entry.status)
                VS_VIRGIN: begin
                    st    = VS_EXCL;
                    owner = tidx;
                    if (cand == '0 && held != '0) begin
                        cand = held;
                    end
                end
                VS_EXCL, VS_SHARED, VS_SHMOD: begin
                    if (rd_entry.status != VS_EXCL || other) begin
                        st = VS_SHMOD;
                    end
                    if (held != '0) begin
                        cand = cand & held;
                    end
                    race = cand == '0;
                end
                default: ;
            endcase
        end
    end

    // Table write: zero fill during the clearing pass, update on an executed read or write
    always_comb begin
        wr_entry  = '0;
        ram_waddr = r_clr_addr;
        ram_we    = i_cmd.clear;
        if (i_cmd.exec) begin
            wr_entry.status = st;
            wr_entry.cand   = cand;
            wr_entry.owner  = owner;
            ram_waddr       = vidx;
            ram_we          = acc_ok;
        end
    end

    lrd_ram #(
        .WIDTH ($bits(t_var_entry)),
        .DEPTH (NUM_VARS)
    ) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.load),
        .i_raddr (VAR_AW'(i_item.var_slot)),
        .o_rdata (rd_entry)
    );

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + VAR_AW'(1);
        end
    end

    assign o_sts.clear_last = r_clr_addr == VAR_AW'(NUM_VARS - 1);

    // Held lock sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_cmd.exec && thr_ok && lock_ok && !is_access) begin
            r_held[tidx][lidx] <= r_item.kind == EV_LOCK;
        end
    end

    // Result and sticky race flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_race_flag <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec && acc_ok && race) begin
                r_race_flag <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.race_now  <= acc_ok && race;
            r_out.race_seen <= r_race_flag || (acc_ok && race);
            r_out.var_state <= acc_ok ? st : VS_VIRGIN;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    // Each executed event yields exactly one result on the next cycle
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_valid)
        else $error("executed event without result");

    // The race flag never drops once set
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_race_flag |=> r_race_flag)
        else $error("race flag cleared");

    // A reported race is always reflected in the sticky flag
    a_race_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.race_now |-> r_out.race_seen && r_race_flag)
        else $error("race not recorded");

endmodule
`default_nettype wire

// ----- rtl/core/lockset_race_detector.sv -----
// The result strobe o_valid is registered from the execute state that follows
// acceptance of start. A new event waits until the last is done: busy is high
// while it executes the read-modify-write of the variable table through its
// single registered-read RAM port. Reset (synchronous, active low) clears the
// lock sets and race flag, then a clearing pass zeroes the 1024-entry variable
// table with busy held high. Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module lockset_race_detector
    import lrd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_lrd_in i_item,
    output logic         o_valid,
    output t_lrd_out     o_result
);

    t_lrd_cmd cmd;
    t_lrd_sts sts;

    lrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lrd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ----- test/lockset_race_detector_tb.sv -----
`timescale 1ns / 1ps
module lockset_race_detector_tb;
    import lrd_pkg::*;

    // One pending transaction; drain_first holds it back until all results are in
    typedef struct packed {
        logic    drain_first;
        t_lrd_in ev;
    } t_stim;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_lrd_in  i_item = '0;
    logic     o_valid;
    t_lrd_out o_result;

    t_stim    stim_q[$];
    t_lrd_out race_verdict_q[$];
    t_lrd_out want;
    logic     taken = 1'b0;
    logic     drain_pending = 1'b0;
    int       gap_left = 0;
    int       calm_left = 0;
    int       mismatches = 0;

    // Shadow copy of the detector tables
    logic [NUM_LOCKS-1:0] held_set  [NUM_THREADS];
    logic [NUM_LOCKS-1:0] wheld_set [NUM_THREADS];
    t_var_st              var_st    [NUM_VARS];
    logic [NUM_LOCKS-1:0] var_cand  [NUM_VARS];
    logic [THR_IDX_W-1:0] var_own   [NUM_VARS];
    logic                 race_latched;

    lockset_race_detector u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lockset refinement for one event; updates the shadow tables
    function automatic t_lrd_out lockset_step(input t_lrd_in ev);
        logic [NUM_LOCKS-1:0] held;
        logic [NUM_LOCKS-1:0] cand;
        t_var_st              st;
        logic                 other;
        logic                 hit;
        t_lrd_out             res;
        hit = 1'b0;
        res = '0;
        case (ev.kind)
            EV_LOCK: begin
                held_set[ev.thread_slot][ev.lock_index] = 1'b1;
            end
            EV_UNLOCK: begin
                held_set[ev.thread_slot][ev.lock_index]  = 1'b0;
                wheld_set[ev.thread_slot][ev.lock_index] = 1'b0;
            end
            default: begin
                held  = held_set[ev.thread_slot];
                st    = var_st[ev.var_slot];
                cand  = var_cand[ev.var_slot];
                other = var_own[ev.var_slot] != ev.thread_slot;
                if (ev.kind == EV_READ) begin
                    case (st)
                        VS_VIRGIN: var_own[ev.var_slot] = ev.thread_slot;
                        VS_EXCL: begin
                            if (held != '0) cand = held;
                            if (other) st = VS_SHARED;
                        end
                        default: begin
                            if (held != '0) cand &= held;
                            if (st == VS_SHMOD && cand == '0) hit = 1'b1;
                        end
                    endcase
                end else begin
                    wheld_set[ev.thread_slot] = held;
                    if (st == VS_VIRGIN) begin
                        st = VS_EXCL;
                        var_own[ev.var_slot] = ev.thread_slot;
                        if (cand == '0 && held != '0) cand = held;
                    end else begin
                        // shared falls through to shared-modified
                        if (st == VS_EXCL) begin
                            if (other) st = VS_SHMOD;
                        end else begin
                            st = VS_SHMOD;
                        end
                        if (held != '0) cand &= held;
                        if (cand == '0) hit = 1'b1;
                    end
                end
                var_st[ev.var_slot]   = st;
                var_cand[ev.var_slot] = cand;
                res.var_state         = st;
            end
        endcase
        if (hit) race_latched = 1'b1;
        res.race_now  = hit;
        res.race_seen = race_latched;
        return res;
    endfunction

    task automatic queue_event(input t_ev_kind k, input int t, input int l, input int v);
        t_stim s;
        s.drain_first    = drain_pending;
        s.ev.kind        = k;
        s.ev.thread_slot = t[THR_IDX_W-1:0];
        s.ev.lock_index  = l[LOCK_IDX_W-1:0];
        s.ev.var_slot    = v[VAR_AW-1:0];
        stim_q.push_back(s);
        drain_pending = 1'b0;
    endtask

    // Idle length after a transaction: mostly short, a few long, some calm stretches
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: launches transactions at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // hold until accepted
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (stim_q.size() != 0
                     && !(stim_q[0].drain_first && race_verdict_q.size() != 0)) begin
            i_item   <= stim_q[0].ev;
            start    <= 1'b1;
            gap_left <= pick_gap();
            void'(stim_q.pop_front());
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: acceptance and result checking at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (race_verdict_q.size() == 0) begin
                    mismatches++;
                    $display({"%0t: mismatch expected no result, ",
                              "got race_now=%0b race_seen=%0b state=%0d"},
                             $time, o_result.race_now, o_result.race_seen,
                             o_result.var_state);
                end else begin
                    want = race_verdict_q.pop_front();
                    if (o_result.race_now !== want.race_now
                        || o_result.race_seen !== want.race_seen
                        || o_result.var_state !== want.var_state) begin
                        mismatches++;
                        $display({"%0t: mismatch expected race_now=%0b race_seen=%0b ",
                                  "state=%0d, got race_now=%0b race_seen=%0b state=%0d"},
                                 $time, want.race_now, want.race_seen, want.var_state,
                                 o_result.race_now, o_result.race_seen,
                                 o_result.var_state);
                    end
                end
            end
            taken <= start && !busy;
            if (start && !busy) race_verdict_q.push_back(lockset_step(i_item));
        end
    end

    initial begin
        int t;
        int nl;
        int na;
        int i;
        int next_drain;
        int lk [2];
        int hot [8];
        for (i = 0; i < NUM_THREADS; i++) begin
            held_set[i]  = '0;
            wheld_set[i] = '0;
        end
        for (i = 0; i < NUM_VARS; i++) begin
            var_st[i]   = VS_VIRGIN;
            var_cand[i] = '0;
            var_own[i]  = '0;
        end
        race_latched = 1'b0;

        // Directed: state walk of variables 0, 1023, 5 and 9 through every state and race path
        queue_event(EV_WRITE, 0, 0, 0);       // virgin -> exclusive, no locks
        queue_event(EV_READ, 0, 0, 0);        // owner read stays exclusive
        queue_event(EV_LOCK, 15, 31, 0);
        queue_event(EV_LOCK, 15, 31, 0);      // relock of a held lock
        queue_event(EV_LOCK, 15, 0, 0);
        queue_event(EV_READ, 15, 0, 1023);    // virgin read sets owner only
        queue_event(EV_WRITE, 15, 0, 1023);   // exclusive, candidates from held set
        queue_event(EV_READ, 3, 0, 1023);     // other thread -> shared
        queue_event(EV_READ, 15, 0, 1023);    // shared refine
        queue_event(EV_WRITE, 15, 0, 1023);   // shared -> shared-modified
        queue_event(EV_UNLOCK, 15, 0, 0);
        queue_event(EV_READ, 3, 0, 1023);     // no locks held: candidates kept
        queue_event(EV_LOCK, 3, 5, 0);
        queue_event(EV_READ, 3, 0, 1023);     // disjoint lock: race on read
        queue_event(EV_WRITE, 15, 0, 1023);   // race on write
        queue_event(EV_UNLOCK, 3, 7, 0);      // unlock of a lock not held
        queue_event(EV_UNLOCK, 3, 5, 0);
        queue_event(EV_UNLOCK, 15, 31, 0);
        queue_event(EV_WRITE, 1, 0, 0);       // other writer on exclusive: race
        queue_event(EV_WRITE, 2, 0, 5);
        queue_event(EV_WRITE, 2, 0, 5);       // owner rewrite with empty set
        queue_event(EV_LOCK, 4, 1, 0);
        queue_event(EV_WRITE, 4, 0, 9);
        queue_event(EV_LOCK, 6, 2, 0);
        queue_event(EV_READ, 6, 0, 9);        // exclusive read replaces candidates
        queue_event(EV_WRITE, 4, 0, 9);

        // Random: locked access episodes on a small set of hot variables, plus noise
        for (i = 0; i < 8; i++) hot[i] = $urandom_range(0, NUM_VARS - 1);
        drain_pending = 1'b1;
        next_drain = stim_q.size() + 300;
        while (stim_q.size() < 1275) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_event(t_ev_kind'($urandom_range(0, 3)), $urandom_range(0, 15),
                            $urandom_range(0, 31), $urandom_range(0, NUM_VARS - 1));
            end else begin
                t  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
                nl = $urandom_range(0, 2);
                na = $urandom_range(1, 4);
                for (i = 0; i < nl; i++) begin
                    lk[i] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, 3);
                    queue_event(EV_LOCK, t, lk[i], 0);
                end
                for (i = 0; i < na; i++)
                    queue_event(t_ev_kind'($urandom_range(0, 1) ? EV_WRITE : EV_READ), t, 0,
                                hot[$urandom_range(0, 7)]);
                for (i = 0; i < nl; i++) begin
                    // occasionally leave a lock held or release the wrong one
                    if ($urandom_range(0, 9) != 0)
                        queue_event(EV_UNLOCK, t,
                                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31)
                                                                 : lk[i], 0);
                end
                if ($urandom_range(0, 3) == 0)
                    hot[$urandom_range(0, 7)] = $urandom_range(0, NUM_VARS - 1);
            end
            if (stim_q.size() >= next_drain) begin
                drain_pending = 1'b1;
                next_drain += 300;
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || start || race_verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && race_verdict_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run time limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
